### hdl/rpvs_pkg.sv
// Package for the reuse-probability victim select unit.
// Holds the fixed field widths and the hit-probability weights of the reuse classes.
// Depends on nothing; every other file of the block uses it.
package rpvs_pkg;

  localparam int WAY_W       = 4;
  localparam int CNT_W       = 16;
  localparam int NUM_CLASSES = 6;
  localparam int WEIGHT_W    = 4;

  // Hit probability of each reuse class in sixteenths.
  localparam logic [WEIGHT_W-1:0] CLASS_WEIGHT [NUM_CLASSES] = '{
    4'd15, 4'd14, 4'd12, 4'd10, 4'd9, 4'd1
  };

endpackage

### hdl/rpvs_if.sv
// Channel interfaces of the reuse-probability victim select unit.
// rpvs_cand_if carries one candidate item, rpvs_victim_if one victim item.
// Depends on rpvs_pkg for the field widths.
interface rpvs_cand_if;
  logic                      valid;
  logic                      ready;
  logic [rpvs_pkg::WAY_W-1:0] way;
  logic [rpvs_pkg::CNT_W-1:0] count_d0;
  logic [rpvs_pkg::CNT_W-1:0] count_d1;
  logic [rpvs_pkg::CNT_W-1:0] count_d2;
  logic [rpvs_pkg::CNT_W-1:0] count_d3;
  logic [rpvs_pkg::CNT_W-1:0] count_d4;
  logic [rpvs_pkg::CNT_W-1:0] count_d5;
  logic                      last_candidate;

  modport source (
    output valid, way, count_d0, count_d1, count_d2, count_d3, count_d4, count_d5,
           last_candidate,
    input  ready
  );
  modport sink (
    input  valid, way, count_d0, count_d1, count_d2, count_d3, count_d4, count_d5,
           last_candidate,
    output ready
  );
endinterface

interface rpvs_victim_if;
  logic                      valid;
  logic                      ready;
  logic [rpvs_pkg::WAY_W-1:0] victim_way;

  modport source (output valid, victim_way, input ready);
  modport sink   (input valid, victim_way, output ready);
endinterface

### hdl/rpvs_intake.sv
// Input stage: forms the weighted sum and the counter sum of one candidate
// and holds them in the input register. Depends on rpvs_pkg and rpvs_cand_if.
module rpvs_intake #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  rpvs_cand_if.sink           cand,
  output logic                a_valid,
  input  logic                a_ready,
  output logic [rpvs_pkg::WAY_W-1:0] a_way,
  output logic [((COUNT_WIDTH < rpvs_pkg::CNT_W) ? COUNT_WIDTH : rpvs_pkg::CNT_W)+5:0] a_wsum,
  output logic [((COUNT_WIDTH < rpvs_pkg::CNT_W) ? COUNT_WIDTH : rpvs_pkg::CNT_W)+2:0] a_csum,
  output logic                a_last
);
  import rpvs_pkg::*;

  localparam int CW     = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
  localparam int WSUM_W = CW + 6;
  localparam int CSUM_W = CW + 3;

  logic [CW-1:0]     counts [NUM_CLASSES];
  logic [WSUM_W-1:0] wsum_next;
  logic [CSUM_W-1:0] csum_raw;
  logic [CSUM_W-1:0] csum_next;
  logic              accept;

  assign counts[0] = cand.count_d0[CW-1:0];
  assign counts[1] = cand.count_d1[CW-1:0];
  assign counts[2] = cand.count_d2[CW-1:0];
  assign counts[3] = cand.count_d3[CW-1:0];
  assign counts[4] = cand.count_d4[CW-1:0];
  assign counts[5] = cand.count_d5[CW-1:0];

  always_comb begin
    wsum_next = '0;
    csum_raw  = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      wsum_next = wsum_next + WSUM_W'(counts[i]) * WSUM_W'(CLASS_WEIGHT[i]);
      csum_raw  = csum_raw + CSUM_W'(counts[i]);
    end
    // An all-zero candidate is held as probability zero over a sum of one.
    csum_next = (csum_raw == '0) ? CSUM_W'(1) : csum_raw;
  end

  assign cand.ready = !a_valid || a_ready;
  assign accept     = cand.valid && cand.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cand.ready) begin
      a_valid <= cand.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_way  <= cand.way;
      a_wsum <= wsum_next;
      a_csum <= csum_next;
      a_last <= cand.last_candidate;
    end
  end

endmodule

### hdl/rpvs_select.sv
// Running-minimum stage: compares each candidate with the best of the set by
// cross-multiplication and loads the victim register on the last candidate.
// Depends on rpvs_pkg and rpvs_victim_if.
module rpvs_select #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                a_valid,
  output logic                a_ready,
  input  logic [rpvs_pkg::WAY_W-1:0] a_way,
  input  logic [((COUNT_WIDTH < rpvs_pkg::CNT_W) ? COUNT_WIDTH : rpvs_pkg::CNT_W)+5:0] a_wsum,
  input  logic [((COUNT_WIDTH < rpvs_pkg::CNT_W) ? COUNT_WIDTH : rpvs_pkg::CNT_W)+2:0] a_csum,
  input  logic                a_last,
  rpvs_victim_if.source       victim
);
  import rpvs_pkg::*;

  localparam int CW     = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
  localparam int WSUM_W = CW + 6;
  localparam int CSUM_W = CW + 3;
  localparam int PROD_W = WSUM_W + CSUM_W;

  logic [WAY_W-1:0]  best_way;
  logic [WSUM_W-1:0] best_wsum;
  logic [CSUM_W-1:0] best_csum;
  logic              have_best;
  logic              out_valid;
  logic [WAY_W-1:0]  out_way;

  logic [PROD_W-1:0] new_cross;
  logic [PROD_W-1:0] best_cross;
  logic              wins;
  logic              proc;
  logic [WAY_W-1:0]  chosen_way;

  assign new_cross  = PROD_W'(a_wsum) * PROD_W'(best_csum);
  assign best_cross = PROD_W'(best_wsum) * PROD_W'(a_csum);
  // Strictly lower only, so the first of equal candidates stays.
  assign wins       = !have_best || (new_cross < best_cross);
  assign chosen_way = wins ? a_way : best_way;

  // Only a last candidate needs room in the victim register.
  assign proc    = a_valid && (!a_last || !out_valid || victim.ready);
  assign a_ready = proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (proc) begin
      have_best <= !a_last;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && wins) begin
      best_way  <= a_way;
      best_wsum <= a_wsum;
      best_csum <= a_csum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && a_last) begin
      out_valid <= 1'b1;
    end else if (victim.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && a_last) begin
      out_way <= chosen_way;
    end
  end

  assign victim.valid      = out_valid;
  assign victim.victim_way = out_way;

endmodule

### hdl/reuse_probability_victim_select_unit.sv
// Victim select by lowest expected hit probability over the candidates of one set.
// The victim item is registered: a last candidate passes the input register, then loads the victim register.
// Throughput: one candidate item per cycle unless a last candidate waits, set by the compare and update of the best.
// A last candidate waits in the input register only while the victim register is full and victim.ready is low.
// Reset (synchronous, rst high) empties both registers and forgets the best candidate.
// Depends on rpvs_pkg, rpvs_if, rpvs_intake and rpvs_select.
module reuse_probability_victim_select_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  rpvs_cand_if.sink     cand,
  rpvs_victim_if.source victim
);
  import rpvs_pkg::*;

  localparam int CW     = (COUNT_WIDTH < CNT_W) ? COUNT_WIDTH : CNT_W;
  localparam int WSUM_W = CW + 6;
  localparam int CSUM_W = CW + 3;

  logic              a_valid;
  logic              a_ready;
  logic [WAY_W-1:0]  a_way;
  logic [WSUM_W-1:0] a_wsum;
  logic [CSUM_W-1:0] a_csum;
  logic              a_last;

  rpvs_intake #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_intake (
    .clk    (clk),
    .rst    (rst),
    .cand   (cand),
    .a_valid(a_valid),
    .a_ready(a_ready),
    .a_way  (a_way),
    .a_wsum (a_wsum),
    .a_csum (a_csum),
    .a_last (a_last)
  );

  rpvs_select #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_select (
    .clk    (clk),
    .rst    (rst),
    .a_valid(a_valid),
    .a_ready(a_ready),
    .a_way  (a_way),
    .a_wsum (a_wsum),
    .a_csum (a_csum),
    .a_last (a_last),
    .victim (victim)
  );

endmodule
